// ===== sv/fhd_pkg.sv =====
// ----------------------------------------------------------------------------
// Fragment header deframer package
// Result beat type and header constants shared by the parser, queue and top.
// ----------------------------------------------------------------------------
package fhd_pkg;

  localparam logic [7:0] FlagFirst     = 8'h01;
  localparam logic [7:0] FlagLast      = 8'h02;
  localparam logic [7:0] FlagEncrypted = 8'h08;
  localparam int unsigned SkipBytes    = 4;

  localparam logic [1:0] IdxChannel   = 2'd0;
  localparam logic [1:0] IdxFlags     = 2'd1;
  localparam logic [1:0] IdxLenHigh   = 2'd2;
  localparam logic [1:0] IdxLenLow    = 2'd3;
  localparam logic [1:0] IdxSkipFinal = 2'(SkipBytes - 1);

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhSkip    = 3'b010,
    PhPayload = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] channel_id;
    logic       first_fragment;
    logic       last_fragment;
    logic       encrypted;
    logic       empty_payload;
    logic       end_of_frame;
  } result_t;

endpackage

// ===== sv/fhd_parser.sv =====
// ----------------------------------------------------------------------------
// Fragment header parser
// Accepts stream bytes, tracks header, skip and payload phases and pushes
// one result beat per payload byte or empty fragment into the queue.
// ----------------------------------------------------------------------------
module fhd_parser import fhd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  output logic       push_o,
  output result_t    result_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  chan_q, chan_d;
  logic [2:0]  flags_q, flags_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] len_full;
  logic        emit;
  logic        emit_empty;
  logic        emit_eof;

  assign len_full = {rem_q[15:8], data_byte_i};

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    chan_d     = chan_q;
    flags_d    = flags_q;
    rem_d      = rem_q;
    emit       = 1'b0;
    emit_empty = 1'b0;
    emit_eof   = 1'b0;
    case (phase_q)
      PhPayload: begin
        rem_d    = rem_q - 16'd1;
        emit     = 1'b1;
        emit_eof = (rem_q == 16'd1);
        if (emit_eof) begin
          phase_d = PhHeader;
          idx_d   = IdxChannel;
        end
      end
      PhSkip: begin
        if (idx_q == IdxSkipFinal) begin
          idx_d = IdxChannel;
          if (rem_q == 16'd0) begin
            phase_d    = PhHeader;
            emit       = 1'b1;
            emit_empty = 1'b1;
            emit_eof   = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      default: begin
        phase_d = PhHeader;
        case (idx_q)
          IdxChannel: begin
            chan_d = data_byte_i;
            idx_d  = IdxFlags;
          end
          IdxFlags: begin
            flags_d = {|(data_byte_i & FlagEncrypted), |(data_byte_i & FlagLast),
                       |(data_byte_i & FlagFirst)};
            idx_d   = IdxLenHigh;
          end
          IdxLenHigh: begin
            rem_d = {data_byte_i, 8'h00};
            idx_d = IdxLenLow;
          end
          default: begin
            rem_d = len_full;
            idx_d = IdxChannel;
            if (flags_q[1:0] == 2'b01) begin
              phase_d = PhSkip;
            end else if (len_full == 16'd0) begin
              emit       = 1'b1;
              emit_empty = 1'b1;
              emit_eof   = 1'b1;
            end else begin
              phase_d = PhPayload;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      idx_q   <= IdxChannel;
      chan_q  <= 8'h00;
      flags_q <= 3'b000;
      rem_q   <= 16'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      chan_q  <= chan_d;
      flags_q <= flags_d;
      rem_q   <= rem_d;
    end
  end

  assign push_o                  = accept_i & emit;
  assign result_o.payload_byte   = emit_empty ? 8'h00 : data_byte_i;
  assign result_o.channel_id     = chan_q;
  assign result_o.first_fragment = flags_q[0];
  assign result_o.last_fragment  = flags_q[1];
  assign result_o.encrypted      = flags_q[2];
  assign result_o.empty_payload  = emit_empty;
  assign result_o.end_of_frame   = emit_eof;

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> rem_q != 16'd0)
    else $error("payload phase with zero remaining length");

  a_payload_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == PhPayload) |-> push_o)
    else $error("payload byte accepted without result");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.empty_payload) |=> phase_q == PhHeader)
    else $error("empty fragment did not return to header phase");

endmodule

// ===== sv/fhd_queue.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Short register queue between parser and output channel; the head entry
// drives the output beat directly.
// ----------------------------------------------------------------------------
module fhd_queue import fhd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    valid_o,
  output result_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t          mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result pushed into full queue");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !pop_i) |=> (valid_o && $stable(rd_ptr_q)))
    else $error("queue head moved without pop");

endmodule

// ===== sv/fragment_header_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Fragment header deframer
// Queueing: each result beat is written into the queue when the byte that causes it is accepted.
// Throughput: one byte per cycle; input stalls only while the result queue
// is full, so output stall backs up after QueueDepth results.
// Reset: parser returns to the header phase with cleared fields; queue empties.
// ----------------------------------------------------------------------------
module fragment_header_deframer_top import fhd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [7:0] channel_id_o,
  output logic       first_fragment_o,
  output logic       last_fragment_o,
  output logic       encrypted_o,
  output logic       empty_payload_o,
  output logic       end_of_frame_o
);

  logic    accept;
  logic    push;
  logic    full;
  result_t result;
  result_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  fhd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .result_o    (result)
  );

  fhd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .pop_i       (~out_stall_i),
    .full_o      (full),
    .valid_o     (out_valid_o),
    .head_o      (head)
  );

  assign payload_byte_o   = head.payload_byte;
  assign channel_id_o     = head.channel_id;
  assign first_fragment_o = head.first_fragment;
  assign last_fragment_o  = head.last_fragment;
  assign encrypted_o      = head.encrypted;
  assign empty_payload_o  = head.empty_payload;
  assign end_of_frame_o   = head.end_of_frame;

endmodule
